[rtl/core/spa_pkg.sv]
// Shared types, constants and lookup tables for the sinusoidal position adder.
// No dependencies; every other file of the block imports this package.
package spa_pkg;

	localparam int unsigned MAX_HIDDEN   = 4096;
	localparam int unsigned MAX_CONTEXT  = 65536;
	localparam int unsigned CORDIC_STEPS = 16;
	localparam int unsigned EXP_BITS     = 24;

	localparam logic [29:0] INV_TWO_PI_Q32  = 30'd683565276;
	localparam logic [33:0] CORDIC_GAIN_Q30 = 34'd652032874;

	localparam logic [1:0] REG_HIDDEN_SIZE    = 2'd0;
	localparam logic [1:0] REG_CONTEXT_LENGTH = 2'd1;
	localparam logic [1:0] REG_POSITION_OFF   = 2'd2;
	localparam logic [1:0] REG_LOG2_STEP      = 2'd3;

	typedef struct packed {
		logic signed [31:0] sample_value;
		logic [15:0]        rel_position;
		logic [11:0]        dim_index;
	} request_t;

	typedef struct packed {
		logic signed [31:0] sum_value;
		logic               saturated;
		logic               range_error;
	} result_t;

	// sideband that travels with each request down the pipe
	typedef struct packed {
		logic signed [31:0] sample;
		logic [15:0]        pos;
		logic [15:0]        k;
		logic               odd;
		logic               err;
	} meta_t;

	// 2^-(2^-(j+1)) in Q0.30
	function automatic logic [29:0] exp2_neg(input logic [4:0] j);
		logic [29:0] r;
		case (j)
			5'd0:  r = 30'd759250125;
			5'd1:  r = 30'd902905651;
			5'd2:  r = 30'd984625594;
			5'd3:  r = 30'd1028218693;
			5'd4:  r = 30'd1050733751;
			5'd5:  r = 30'd1062175491;
			5'd6:  r = 30'd1067942999;
			5'd7:  r = 30'd1070838486;
			5'd8:  r = 30'd1072289173;
			5'd9:  r = 30'd1073015252;
			5'd10: r = 30'd1073378477;
			5'd11: r = 30'd1073560135;
			5'd12: r = 30'd1073650976;
			5'd13: r = 30'd1073696399;
			5'd14: r = 30'd1073719111;
			5'd15: r = 30'd1073730468;
			5'd16: r = 30'd1073736146;
			5'd17: r = 30'd1073738985;
			5'd18: r = 30'd1073740404;
			5'd19: r = 30'd1073741114;
			5'd20: r = 30'd1073741469;
			5'd21: r = 30'd1073741647;
			5'd22: r = 30'd1073741735;
			5'd23: r = 30'd1073741780;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

	// arctangent of 2^-i in Q0.32 turns
	function automatic logic [29:0] atan_turn(input logic [4:0] i);
		logic [29:0] r;
		case (i)
			5'd0:  r = 30'd536870912;
			5'd1:  r = 30'd316933406;
			5'd2:  r = 30'd167458907;
			5'd3:  r = 30'd85004756;
			5'd4:  r = 30'd42667331;
			5'd5:  r = 30'd21354465;
			5'd6:  r = 30'd10679838;
			5'd7:  r = 30'd5340245;
			5'd8:  r = 30'd2670163;
			5'd9:  r = 30'd1335087;
			5'd10: r = 30'd667544;
			5'd11: r = 30'd333772;
			5'd12: r = 30'd166886;
			5'd13: r = 30'd83443;
			5'd14: r = 30'd41722;
			5'd15: r = 30'd20861;
			5'd16: r = 30'd10430;
			5'd17: r = 30'd5215;
			5'd18: r = 30'd2608;
			5'd19: r = 30'd1304;
			5'd20: r = 30'd652;
			5'd21: r = 30'd326;
			5'd22: r = 30'd163;
			5'd23: r = 30'd81;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage

[rtl/core/spa_exp2.sv]
// Pipelined table exp2 of the fractional exponent, then scale by 1/(2*pi).
// Depends on spa_pkg. One multiply per stage, 25 stages.
module spa_exp2 (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  spa_pkg::meta_t     in_meta,
	input  logic [23:0]        in_frac,
	output logic               out_valid,
	output spa_pkg::meta_t     out_meta,
	output logic [46:0]        out_w
);
	import spa_pkg::*;

	logic        valid_s [0:EXP_BITS];
	meta_t       meta_s  [0:EXP_BITS];
	logic [23:0] frac_s  [0:EXP_BITS];
	logic [30:0] m_s     [0:EXP_BITS];
	logic        w_valid_s1;
	meta_t       w_meta_s1;
	logic [46:0] w_s1;
	logic [60:0] w_prod;

	assign valid_s[0] = in_valid;
	assign meta_s[0]  = in_meta;
	assign frac_s[0]  = in_frac;
	assign m_s[0]     = 31'h4000_0000;

	for (genvar j = 0; j < EXP_BITS; j++) begin : g_step
		logic [60:0] prod;
		assign prod = 61'(m_s[j]) * 61'(exp2_neg(5'(j)));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j+1] <= 1'b0;
			end else begin
				valid_s[j+1] <= valid_s[j];
			end
		end

		always_ff @(posedge clk) begin
			meta_s[j+1] <= meta_s[j];
			frac_s[j+1] <= frac_s[j];
			m_s[j+1]    <= frac_s[j][EXP_BITS-1-j] ? prod[60:30] : m_s[j];
		end
	end

	assign w_prod = 61'(m_s[EXP_BITS]) * 61'(INV_TWO_PI_Q32);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_valid_s1 <= 1'b0;
		end else begin
			w_valid_s1 <= valid_s[EXP_BITS];
		end
	end

	always_ff @(posedge clk) begin
		w_meta_s1 <= meta_s[EXP_BITS];
		w_s1      <= w_prod[60:14];
	end

	assign out_valid = w_valid_s1;
	assign out_meta  = w_meta_s1;
	assign out_w     = w_s1;
endmodule

[rtl/core/spa_cordic.sv]
// Quadrant fold and fixed-step rotation CORDIC on a Q0.32 turn angle.
// Depends on spa_pkg. One load stage plus one stage per rotation.
module spa_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  spa_pkg::meta_t      in_meta,
	input  logic [31:0]         in_turn,
	output logic                out_valid,
	output spa_pkg::meta_t      out_meta,
	output logic [1:0]          out_quad,
	output logic signed [33:0]  out_x,
	output logic signed [33:0]  out_y
);
	import spa_pkg::*;

	logic               valid_s [0:CORDIC_STEPS];
	meta_t              meta_s  [0:CORDIC_STEPS];
	logic [1:0]         quad_s  [0:CORDIC_STEPS];
	logic signed [33:0] x_s     [0:CORDIC_STEPS];
	logic signed [33:0] y_s     [0:CORDIC_STEPS];
	logic signed [33:0] z_s     [0:CORDIC_STEPS];
	logic [31:0]        turn_rnd;
	logic [31:0]        resid;

	assign turn_rnd = in_turn + 32'h2000_0000;
	assign resid    = in_turn - {turn_rnd[31:30], 30'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		meta_s[0] <= in_meta;
		quad_s[0] <= turn_rnd[31:30];
		x_s[0]    <= CORDIC_GAIN_Q30;
		y_s[0]    <= '0;
		z_s[0]    <= {{2{resid[31]}}, resid};
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		logic signed [33:0] dx;
		logic signed [33:0] dy;
		logic signed [33:0] da;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign da = signed'({4'd0, atan_turn(5'(i))});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else begin
				valid_s[i+1] <= valid_s[i];
			end
		end

		always_ff @(posedge clk) begin
			meta_s[i+1] <= meta_s[i];
			quad_s[i+1] <= quad_s[i];
			if (!z_s[i][33]) begin
				x_s[i+1] <= x_s[i] - dx;
				y_s[i+1] <= y_s[i] + dy;
				z_s[i+1] <= z_s[i] - da;
			end else begin
				x_s[i+1] <= x_s[i] + dx;
				y_s[i+1] <= y_s[i] - dy;
				z_s[i+1] <= z_s[i] + da;
			end
		end
	end

	assign out_valid = valid_s[CORDIC_STEPS];
	assign out_meta  = meta_s[CORDIC_STEPS];
	assign out_quad  = quad_s[CORDIC_STEPS];
	assign out_x     = x_s[CORDIC_STEPS];
	assign out_y     = y_s[CORDIC_STEPS];
endmodule

[rtl/core/sinusoidal_position_add_top.sv]
// Sinusoidal position adder: range check, exp2 frequency, angle, CORDIC, sum.
// One request accepted every cycle.
// The 24-step exp2 multiply chain and the 16 CORDIC rotations set the depth.
// busy stays low: the pipe never stalls. Reset clears the valid bits and
// loads the register defaults; results show on done for one cycle.
module sinusoidal_position_add_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  spa_pkg::request_t  request,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [28:0]        cfg_data,
	output logic               done,
	output spa_pkg::result_t   result
);
	import spa_pkg::*;

	logic [12:0] hidden_size_q;
	logic [16:0] context_length_q;
	logic [16:0] position_offset_q;
	logic [28:0] log2_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hidden_size_q     <= 13'd4096;
			context_length_q  <= 17'd65536;
			position_offset_q <= 17'd0;
			log2_step_q       <= 29'd13060;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HIDDEN_SIZE:    hidden_size_q     <= cfg_data[12:0];
				REG_CONTEXT_LENGTH: context_length_q  <= cfg_data[16:0];
				REG_POSITION_OFF:   position_offset_q <= cfg_data[16:0];
				REG_LOG2_STEP:      log2_step_q       <= cfg_data;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: range check and exponent product
	logic        accept;
	logic [17:0] pos_abs;
	logic [16:0] lim_ctx;
	logic [12:0] lim_hid;
	logic        err;
	logic [39:0] expo;
	logic        valid_s1;
	meta_t       meta_s1;
	logic [23:0] frac_s1;

	assign accept  = start && !busy;
	assign pos_abs = 18'(position_offset_q) + 18'(request.rel_position);
	assign lim_ctx = (context_length_q < 17'(MAX_CONTEXT)) ? context_length_q
		: 17'(MAX_CONTEXT);
	assign lim_hid = (hidden_size_q < 13'(MAX_HIDDEN)) ? hidden_size_q : 13'(MAX_HIDDEN);
	assign err     = (pos_abs >= 18'(lim_ctx)) || (13'(request.dim_index) >= lim_hid);
	assign expo    = 40'(request.dim_index[11:1]) * 40'(log2_step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		meta_s1.sample <= request.sample_value;
		meta_s1.pos    <= pos_abs[15:0];
		meta_s1.k      <= expo[39:24];
		meta_s1.odd    <= request.dim_index[0];
		meta_s1.err    <= err;
		frac_s1        <= expo[23:0];
	end

	logic        w_valid;
	meta_t       w_meta;
	logic [46:0] w_val;

	spa_exp2 u_exp2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_meta   (meta_s1),
		.in_frac   (frac_s1),
		.out_valid (w_valid),
		.out_meta  (w_meta),
		.out_w     (w_val)
	);

	// angle: position times frequency, then shift down by the integer exponent
	logic        valid_p_s1;
	meta_t       meta_p_s1;
	logic [62:0] prod_p_s1;
	logic        valid_t_s2;
	meta_t       meta_t_s2;
	logic [31:0] turn_t_s2;
	logic [16:0] shamt;
	logic [62:0] shifted;

	assign shamt   = 17'(meta_p_s1.k) + 17'd16;
	assign shifted = prod_p_s1 >> shamt[5:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_p_s1 <= 1'b0;
			valid_t_s2 <= 1'b0;
		end else begin
			valid_p_s1 <= w_valid;
			valid_t_s2 <= valid_p_s1;
		end
	end

	always_ff @(posedge clk) begin
		meta_p_s1 <= w_meta;
		prod_p_s1 <= 63'(w_meta.pos) * 63'(w_val);
		meta_t_s2 <= meta_p_s1;
		turn_t_s2 <= (shamt > 17'd63) ? 32'd0 : shifted[31:0];
	end

	logic               c_valid;
	meta_t              c_meta;
	logic [1:0]         c_quad;
	logic signed [33:0] c_x;
	logic signed [33:0] c_y;

	spa_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_t_s2),
		.in_meta   (meta_t_s2),
		.in_turn   (turn_t_s2),
		.out_valid (c_valid),
		.out_meta  (c_meta),
		.out_quad  (c_quad),
		.out_x     (c_x),
		.out_y     (c_y)
	);

	// output: quadrant, round to Q1.15, add twice to sample, saturate
	logic signed [33:0] sel;
	logic signed [33:0] rnd;
	logic signed [18:0] q15_wide;
	logic signed [15:0] q15;
	logic signed [33:0] sum_wide;
	logic               sat_hi;
	logic               sat_lo;
	logic               done_q;
	result_t            result_q;

	always_comb begin
		case ({c_meta.odd, c_quad})
			3'b000: sel = c_y;
			3'b001: sel = c_x;
			3'b010: sel = -c_y;
			3'b011: sel = -c_x;
			3'b100: sel = c_x;
			3'b101: sel = -c_y;
			3'b110: sel = -c_x;
			default: sel = c_y;
		endcase
	end

	assign rnd      = sel + 34'sd16384;
	assign q15_wide = 19'(rnd >>> 15);
	assign q15      = (q15_wide > 19'sd32767) ? 16'sh7fff
		: (q15_wide < -19'sd32768) ? 16'sh8000 : q15_wide[15:0];
	assign sum_wide = 34'(c_meta.sample) + (34'(q15) <<< 1);
	assign sat_hi   = sum_wide > 34'sh0_7fff_ffff;
	assign sat_lo   = sum_wide < -34'sh0_8000_0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= c_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (c_meta.err) begin
			result_q.sum_value   <= '0;
			result_q.saturated   <= 1'b0;
			result_q.range_error <= 1'b1;
		end else begin
			result_q.sum_value   <= sat_hi ? 32'sh7fff_ffff
				: sat_lo ? 32'sh8000_0000 : sum_wide[31:0];
			result_q.saturated   <= sat_hi || sat_lo;
			result_q.range_error <= 1'b0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.range_error |-> result.sum_value == 0 && !result.saturated)
		else $error("range error result not cleared");

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.saturated |->
		(result.sum_value == 32'sh7fff_ffff || result.sum_value == 32'sh8000_0000))
		else $error("saturated flag without clipped value");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 46))
		else $error("result without matching request");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("pipe reported busy");
endmodule
